>>> rtl/core/cdes_pkg.sv
// Shared types, constants and the month offset table for the date to seconds pipeline.
package cdes_pkg;

  localparam int unsigned YearLow   = 70;
  localparam int unsigned YearHigh  = 120;
  localparam int unsigned DaysWidth = 16;

  localparam logic [7:0] YEAR_LOW  = 8'(YearLow);
  localparam logic [7:0] YEAR_HIGH = 8'(YearHigh);

  // Day count since 1970-01-01 plus the range flag, handed from the day stage.
  typedef struct packed {
    logic signed [DaysWidth-1:0] days;
    logic                        oor;
  } cdes_day_t;

  // Days before month m = month_index + 1, from (m * 3057 - 3007) / 100.
  // Indexes 12..15 run on past December.
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] r;
    case (mon)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/cdes_day_count.sv
// Day number since 1970-01-01 from year, month and day of month.
module cdes_day_count import cdes_pkg::*; (
  input  logic [7:0] year_since_1900,
  input  logic [3:0] month_index,
  input  logic [4:0] day_of_month,
  output cdes_day_t  day
);

  logic [5:0]                  yrs;      // whole years since 1970
  logic [6:0]                  yrs_p1;
  logic                        leap;
  logic [1:0]                  adj;
  logic signed [DaysWidth-1:0] sum;

  always_comb begin
    yrs    = 6'(year_since_1900 - YEAR_LOW);
    yrs_p1 = {1'b0, yrs} + 7'd1;
    // Within 1970..2020 the century rules never bite: 2000 is leap anyway.
    leap   = (year_since_1900[1:0] == 2'b00);
    if (month_index >= 4'd2) begin
      adj = leap ? 2'd1 : 2'd2;
    end else begin
      adj = 2'd0;
    end
    sum = $signed(DaysWidth'(yrs) * DaysWidth'(365))
        + $signed(DaysWidth'(yrs_p1[6:2]))              // leap days passed
        + $signed(DaysWidth'(days_before_month(month_index)))
        + $signed(DaysWidth'(day_of_month))
        - $signed(DaysWidth'(adj))
        - $signed(DaysWidth'(1));
    day.days = sum;
    day.oor  = (year_since_1900 < YEAR_LOW) || (year_since_1900 > YEAR_HIGH);
  end

endmodule

>>> rtl/core/calendar_date_to_epoch_seconds_top.sv
// Top level: four stage pipeline converting a broken-down date and time to epoch seconds.
//
// Converts one date and time per clock to seconds since 1970-01-01 00:00:00 whenever
// out_stall lets the pipeline move. The stages are: day count (year, month table and
// day), days * 24 + hour, hours * 60 + minute, and minutes * 60 + second with
// clamping, the last being the output register. Each stage holds its own valid bit
// and moves on whenever the stage after it is empty or moving, so bubbles close up
// and in_stall rises only once every stage is full and out_stall is high. Years
// outside 70..120 (1970..2020) give year_out_of_range = 1 and epoch_seconds = 0. Day
// of month is not checked against the month; a negative total (day 0 early on
// 1970-01-01) clamps to zero.
module calendar_date_to_epoch_seconds_top import cdes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  year_since_1900,
  input  logic [3:0]  month_index,
  input  logic [4:0]  day_of_month,
  input  logic [4:0]  hour_of_day,
  input  logic [5:0]  minute_of_hour,
  input  logic [5:0]  second_of_minute,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] epoch_seconds,
  output logic        year_out_of_range
);

  // Stage A: days
  logic                        va;
  logic signed [DaysWidth-1:0] a_days;
  logic [4:0]                  a_hr;
  logic [5:0]                  a_mi;
  logic [5:0]                  a_se;
  logic                        a_oor;
  // Stage B: hours
  logic                        vb;
  logic signed [20:0]          b_hours;
  logic [5:0]                  b_mi;
  logic [5:0]                  b_se;
  logic                        b_oor;
  // Stage C: minutes
  logic                        vc;
  logic signed [26:0]          c_mins;
  logic [5:0]                  c_se;
  logic                        c_oor;

  logic adv_a, adv_b, adv_c, adv_d;

  cdes_day_t          day;
  logic signed [20:0] b_hours_next;
  logic signed [26:0] c_mins_next;
  logic signed [32:0] secs;

  // Advance chain: a stage may load when it is empty or its content moves on.
  always_comb begin
    adv_d    = !out_valid || !out_stall;
    adv_c    = !vc || adv_d;
    adv_b    = !vb || adv_c;
    adv_a    = !va || adv_b;
    in_stall = !adv_a;
  end

  cdes_day_count u_day (
    .year_since_1900 (year_since_1900),
    .month_index     (month_index),
    .day_of_month    (day_of_month),
    .day             (day)
  );

  always_comb begin
    b_hours_next = 21'(a_days) * 21'sd24 + $signed({16'd0, a_hr});
    c_mins_next  = 27'(b_hours) * 27'sd60 + $signed({21'd0, b_mi});
    secs         = 33'(c_mins) * 33'sd60 + $signed({27'd0, c_se});
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) va        <= in_valid;
      if (adv_b) vb        <= va;
      if (adv_c) vc        <= vb;
      if (adv_d) out_valid <= vc;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_days <= day.days;
      a_oor  <= day.oor;
      a_hr   <= hour_of_day;
      a_mi   <= minute_of_hour;
      a_se   <= second_of_minute;
    end
    if (adv_b) begin
      b_hours <= b_hours_next;
      b_mi    <= a_mi;
      b_se    <= a_se;
      b_oor   <= a_oor;
    end
    if (adv_c) begin
      c_mins <= c_mins_next;
      c_se   <= b_se;
      c_oor  <= b_oor;
    end
    if (adv_d) begin
      // out-of-range year or negative total both give zero
      if (c_oor || secs[32]) begin
        epoch_seconds <= '0;
      end else begin
        epoch_seconds <= secs[30:0];
      end
      year_out_of_range <= c_oor;
    end
  end

  // Checks
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && year_out_of_range |-> epoch_seconds == '0)
    else $error("out-of-range year with non-zero seconds");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> va && vb && vc && out_valid && out_stall)
    else $error("input stalled while pipeline has room");

  a_hold_a: assert property (@(posedge clk) disable iff (rst)
    va && !adv_b |=> va && $stable(a_days) && $stable(a_oor))
    else $error("stage A lost or changed a held item");

endmodule

>>> sim/calendar_date_to_epoch_seconds_top_test.sv
// Self-checking testbench for the date and time to epoch seconds pipeline.
module calendar_date_to_epoch_seconds_top_test;
  import cdes_pkg::*;

  // One broken-down date and time, at the port widths.
  typedef struct {
    logic [7:0] year;
    logic [3:0] mon;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } date_item_t;

  // What the pipeline should hand back for one date.
  typedef struct {
    logic [30:0] secs;
    logic        oor;
  } epoch_result_t;

  // Cycles with no item moving on either side before the run is declared hung.
  // The slowest correct stretch is a long sender gap or a long receiver stall
  // plus the pass through the four pipeline stages, so this is ample.
  localparam int unsigned HangLimit  = 2000;
  localparam int unsigned RandItems  = 2000;
  localparam int unsigned TailCycles = 12;
  localparam int unsigned MaxReports = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  year_since_1900 = '0;
  logic [3:0]  month_index = '0;
  logic [4:0]  day_of_month = '0;
  logic [4:0]  hour_of_day = '0;
  logic [5:0]  minute_of_hour = '0;
  logic [5:0]  second_of_minute = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] epoch_seconds;
  logic        year_out_of_range;

  date_item_t    pending_dates[$];
  epoch_result_t awaited_seconds[$];

  bit          in_taken;       // the item on the input ports has been accepted
  int unsigned send_gap;       // idle cycles still to insert before the next item
  int unsigned items_sent;
  int unsigned stall_left;     // stall cycles still to hold on the output
  int unsigned cycle_no;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned oor_seen;
  int unsigned zero_seen;
  bit          progress;
  date_item_t  next_date;
  epoch_result_t got;
  epoch_result_t want;

  calendar_date_to_epoch_seconds_top u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .year_since_1900   (year_since_1900),
    .month_index       (month_index),
    .day_of_month      (day_of_month),
    .hour_of_day       (hour_of_day),
    .minute_of_hour    (minute_of_hour),
    .second_of_minute  (second_of_minute),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .epoch_seconds     (epoch_seconds),
    .year_out_of_range (year_out_of_range)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Scalar Gregorian day number of year y, month m (from 1) and day d.
  // Month offsets follow (m * 3057 - 3007) / 100, so months past December
  // simply keep counting; leap years drop one day less past February.
  function automatic longint gregorian_day(input longint y, input longint m, input longint d);
    longint n;
    longint p;
    bit     leap;
    n = d + (m * 3057 - 3007) / 100;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    if (m > 2) n -= leap ? 1 : 2;
    p = y - 1;
    n += p * 365 + p / 4 - p / 100 + p / 400;
    return n;
  endfunction

  // Expected seconds since 1970-01-01 00:00:00 for one date and time.
  function automatic epoch_result_t date_to_seconds(input date_item_t d);
    epoch_result_t r;
    longint        t;
    if (d.year < YearLow || d.year > YearHigh) begin
      r.secs = '0;
      r.oor  = 1'b1;
      return r;
    end
    t = gregorian_day(longint'(d.year) + 1900, longint'(d.mon) + 1, longint'(d.day))
        - gregorian_day(1970, 1, 1);
    t = t * 24 + longint'(d.hour);
    t = t * 60 + longint'(d.minute);
    t = t * 60 + longint'(d.second);
    // Only day 0 early on 1970-01-01 goes negative; it clamps to zero.
    if (t < 0) t = 0;
    r.secs = t[30:0];
    r.oor  = 1'b0;
    return r;
  endfunction

  function automatic date_item_t make_date(input int y, input int m, input int d,
                                           input int h, input int mi, input int s);
    date_item_t x;
    x.year   = 8'(y);
    x.mon    = 4'(m);
    x.day    = 5'(d);
    x.hour   = 5'(h);
    x.minute = 6'(mi);
    x.second = 6'(s);
    return x;
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Input driver: changes only at the falling edge. A presented item is held
  // until the monitor has seen it accepted, then an optional gap follows.
  // Every fourth block of 100 items goes out back to back with no gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: hold the item unchanged
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
      in_taken = 1'b0;
    end else if (pending_dates.size() > 0) begin
      next_date = pending_dates.pop_front();
      year_since_1900  <= next_date.year;
      month_index      <= next_date.mon;
      day_of_month     <= next_date.day;
      hour_of_day      <= next_date.hour;
      minute_of_hour   <= next_date.minute;
      second_of_minute <= next_date.second;
      in_valid <= 1'b1;
      in_taken = 1'b0;
      items_sent++;
      send_gap = ((items_sent % 400) < 100) ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
      in_taken = 1'b0;
    end
  end

  // Output back-pressure, also at the falling edge. No new stall starts while
  // cycle_no % 512 is below 128, so the pipeline also runs flat out.
  always @(negedge clk) begin
    cycle_no++;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ((cycle_no % 512) >= 128 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Monitor at the rising edge: checks each accepted result against the
  // oldest expectation, records accepted input items, and watches for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        got.secs = epoch_seconds;
        got.oor  = year_out_of_range;
        if (awaited_seconds.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("%0t: result with none expected: epoch_seconds %0d oor %0b",
                     $time, got.secs, got.oor);
        end else begin
          want = awaited_seconds.pop_front();
          results_checked++;
          if (want.oor) oor_seen++;
          else if (want.secs == 0) zero_seen++;
          if (got.secs !== want.secs) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: epoch_seconds expected %0d, actual %0d",
                       $time, want.secs, got.secs);
          end
          if (got.oor !== want.oor) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("%0t: year_out_of_range expected %0b, actual %0b",
                       $time, want.oor, got.oor);
          end
        end
      end
      if (in_valid && !in_stall) begin
        progress = 1'b1;
        next_date.year   = year_since_1900;
        next_date.mon    = month_index;
        next_date.day    = day_of_month;
        next_date.hour   = hour_of_day;
        next_date.minute = minute_of_hour;
        next_date.second = second_of_minute;
        awaited_seconds.push_back(date_to_seconds(next_date));
        in_taken = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= HangLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    date_item_t  d;

    // Directed items: epoch origin, span edges, clamping, leap days,
    // months past December, unchecked days and full-width fields.
    pending_dates.push_back(make_date(70, 0, 1, 0, 0, 0));      // epoch origin
    pending_dates.push_back(make_date(70, 0, 0, 0, 0, 0));      // negative, clamps
    pending_dates.push_back(make_date(70, 0, 0, 23, 59, 60));   // sums to exactly zero
    pending_dates.push_back(make_date(70, 0, 0, 23, 59, 59));   // one second short
    pending_dates.push_back(make_date(69, 11, 31, 23, 59, 59)); // just below span
    pending_dates.push_back(make_date(121, 0, 1, 0, 0, 0));     // just above span
    pending_dates.push_back(make_date(0, 0, 0, 0, 0, 0));
    pending_dates.push_back(make_date(255, 15, 31, 31, 63, 63));
    pending_dates.push_back(make_date(120, 11, 31, 23, 59, 60)); // last natural second
    pending_dates.push_back(make_date(120, 15, 31, 31, 63, 63)); // largest total
    pending_dates.push_back(make_date(100, 1, 29, 12, 0, 0));   // 29 Feb 2000
    pending_dates.push_back(make_date(100, 2, 1, 0, 0, 0));
    pending_dates.push_back(make_date(72, 1, 29, 6, 30, 0));    // first leap day
    pending_dates.push_back(make_date(73, 2, 1, 0, 0, 0));      // non-leap March
    pending_dates.push_back(make_date(99, 11, 31, 23, 59, 59));
    pending_dates.push_back(make_date(80, 12, 1, 0, 0, 0));     // months past December
    pending_dates.push_back(make_date(80, 13, 15, 1, 2, 3));
    pending_dates.push_back(make_date(80, 14, 20, 4, 5, 6));
    pending_dates.push_back(make_date(85, 6, 15, 0, 0, 60));    // leap second
    pending_dates.push_back(make_date(110, 3, 31, 10, 10, 10)); // 31 April, not checked
    pending_dates.push_back(make_date(90, 0, 0, 0, 0, 0));      // day zero mid-span
    pending_dates.push_back(make_date(95, 5, 10, 31, 63, 63));  // hour/min/sec overrun

    // Random items: mostly well-formed dates, some with full-width fields
    // inside the span, and some with any year at all.
    for (int unsigned i = 0; i < RandItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        d = make_date($urandom_range(YearLow, YearHigh), $urandom_range(0, 11),
                      $urandom_range(1, 31), $urandom_range(0, 23),
                      $urandom_range(0, 59), $urandom_range(0, 60));
      end else begin
        d = make_date($urandom_range(YearLow, YearHigh), $urandom, $urandom,
                      $urandom, $urandom, $urandom);
        if (pick >= 85) d.year = 8'($urandom);
      end
      pending_dates.push_back(d);
    end

    // Reset once, released at a falling edge.
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Wait until every item has gone in and every result has come back,
    // then let the pipeline run on a little to catch stray results.
    while (pending_dates.size() != 0 || in_valid || awaited_seconds.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("checked %0d results: %0d with year out of span, %0d clamped or zero",
             results_checked, oor_seen, zero_seen);
    $display("random gaps on input and stalls on output, with gap-free stretches");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
